[hw/rtl/websocket_frame_deframer_assert.svh]
// Assertion macros for the WebSocket deframer RTL.
// Included by the modules that check their own control logic; no other dependencies.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
`define WSFD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("wsfd assertion failed");
`define WSFD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("wsfd assertion failed");
`else
`define WSFD_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define WSFD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

[hw/rtl/wsfd_pkg.sv]
// Types, codes and helper functions for the WebSocket deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package wsfd_pkg;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  typedef enum logic [2:0] {
    PH_B0  = 3'd0,
    PH_B1  = 3'd1,
    PH_EXT = 3'd2,
    PH_KEY = 3'd3,
    PH_PAY = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HDR     = 2'd0,
    KIND_HDR_END = 2'd1,
    KIND_PAYLOAD = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic        frame_last;
    logic        fin_flag;
    logic [2:0]  rsv_bits;
    logic [3:0]  frame_opcode;
    logic        masked_flag;
    logic [62:0] frame_length;
    logic [3:0]  header_bytes;
  } res_t;

  function automatic logic [3:0] ext_size(input logic [6:0] slen);
    logic [3:0] r;
    r = 4'd0;
    if (slen == LEN_CODE_16) r = 4'd2;
    if (slen == LEN_CODE_64) r = 4'd8;
    return r;
  endfunction

  function automatic logic [3:0] hdr_size(input logic mask, input logic [6:0] slen);
    return 4'd2 + ext_size(slen) + (mask ? 4'd4 : 4'd0);
  endfunction

endpackage

[hw/rtl/wsfd_parser.sv]
// Frame header state machine, length/key capture and payload unmasking.
// Depends on wsfd_pkg and websocket_frame_deframer_assert.svh.
`timescale 1ns / 1ps
`include "websocket_frame_deframer_assert.svh"
module wsfd_parser #(
  parameter int LENGTH_BITS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    data_byte_i,
  output wsfd_pkg::res_t res_o
);
  import wsfd_pkg::*;

  localparam int LB = LENGTH_BITS;

  phase_e           phase_q, phase_d;
  logic [3:0]       hcnt_q, hcnt_d;
  logic             fin_q, fin_d;
  logic [2:0]       rsv_q, rsv_d;
  logic [3:0]       opc_q, opc_d;
  logic             mask_q, mask_d;
  logic [6:0]       slen_q, slen_d;
  logic [LB-1:0]    len_q, len_d;
  logic [31:0]      key_q, key_d;
  logic [LB-1:0]    pcnt_q, pcnt_d;

  logic [3:0]       hcnt_inc;
  logic [LB:0]      pcnt_inc;
  logic [7:0]       key_byte;
  kind_e            kind;
  logic             last;
  logic [7:0]       ob;
  logic [63:0]      len_wide;

  assign hcnt_inc = hcnt_q + 4'd1;
  assign pcnt_inc = {1'b0, pcnt_q} + {{LB{1'b0}}, 1'b1};

  always_comb begin
    case (pcnt_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      2'd3:    key_byte = key_q[7:0];
      default: key_byte = 8'd0;
    endcase
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    hcnt_d  = hcnt_q;
    fin_d   = fin_q;
    rsv_d   = rsv_q;
    opc_d   = opc_q;
    mask_d  = mask_q;
    slen_d  = slen_q;
    len_d   = len_q;
    key_d   = key_q;
    pcnt_d  = pcnt_q;
    kind    = KIND_HDR;
    last    = 1'b0;
    ob      = 8'd0;
    case (phase_q)
      PH_B0: begin
        fin_d   = data_byte_i[7];
        rsv_d   = data_byte_i[6:4];
        opc_d   = data_byte_i[3:0];
        mask_d  = 1'b0;
        slen_d  = 7'd0;
        len_d   = '0;
        key_d   = 32'd0;
        pcnt_d  = '0;
        hcnt_d  = 4'd1;
        phase_d = PH_B1;
      end
      PH_B1: begin
        mask_d = data_byte_i[7];
        slen_d = data_byte_i[6:0];
        hcnt_d = 4'd2;
        len_d  = '0;
        if (ext_size(data_byte_i[6:0]) != 4'd0) begin
          phase_d = PH_EXT;
        end else begin
          len_d[6:0] = data_byte_i[6:0];
          if (data_byte_i[7]) begin
            phase_d = PH_KEY;
          end else begin
            kind   = KIND_HDR_END;
            pcnt_d = '0;
            if (data_byte_i[6:0] == 7'd0) begin
              phase_d = PH_B0;
              last    = 1'b1;
            end else begin
              phase_d = PH_PAY;
            end
          end
        end
      end
      PH_EXT: begin
        len_d  = {len_q[LB-9:0], data_byte_i};
        hcnt_d = hcnt_inc;
        if (hcnt_inc >= 4'd2 + ext_size(slen_q)) begin
          if (mask_q) begin
            phase_d = PH_KEY;
          end else begin
            kind   = KIND_HDR_END;
            pcnt_d = '0;
            if (len_d == '0) begin
              phase_d = PH_B0;
              last    = 1'b1;
            end else begin
              phase_d = PH_PAY;
            end
          end
        end
      end
      PH_KEY: begin
        key_d  = {key_q[23:0], data_byte_i};
        hcnt_d = hcnt_inc;
        if (hcnt_inc >= hdr_size(mask_q, slen_q)) begin
          kind   = KIND_HDR_END;
          pcnt_d = '0;
          if (len_q == '0) begin
            phase_d = PH_B0;
            last    = 1'b1;
          end else begin
            phase_d = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        ob     = data_byte_i ^ (mask_q ? key_byte : 8'd0);
        kind   = KIND_PAYLOAD;
        pcnt_d = pcnt_inc[LB-1:0];
        if (pcnt_inc >= {1'b0, len_q}) begin
          last    = 1'b1;
          phase_d = PH_B0;
        end
      end
      default: phase_d = PH_B0;
    endcase
  end

  // result fields
  assign len_wide = 64'(len_d);

  always_comb begin
    res_o.kind         = kind;
    res_o.out_byte     = ob;
    res_o.frame_last   = last;
    res_o.fin_flag     = fin_d;
    res_o.rsv_bits     = rsv_d;
    res_o.frame_opcode = opc_d;
    res_o.masked_flag  = mask_d;
    res_o.frame_length = len_wide[62:0];
    res_o.header_bytes = hdr_size(mask_d, slen_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_B0;
      hcnt_q  <= 4'd0;
      fin_q   <= 1'b0;
      rsv_q   <= 3'd0;
      opc_q   <= 4'd0;
      mask_q  <= 1'b0;
      slen_q  <= 7'd0;
      len_q   <= '0;
      key_q   <= 32'd0;
      pcnt_q  <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      fin_q   <= fin_d;
      rsv_q   <= rsv_d;
      opc_q   <= opc_d;
      mask_q  <= mask_d;
      slen_q  <= slen_d;
      len_q   <= len_d;
      key_q   <= key_d;
      pcnt_q  <= pcnt_d;
    end
  end

  `WSFD_ASSERT_IMPL(a_key_needs_mask, clk_i, rst_ni, phase_q == PH_KEY, mask_q)
  `WSFD_ASSERT_IMPL(a_pay_count_below_len, clk_i, rst_ni, phase_q == PH_PAY, pcnt_q < len_q)
  `WSFD_ASSERT_NEXT(a_pay_exit_to_b0, clk_i, rst_ni, accept_i && phase_q == PH_PAY,
                    phase_q == PH_PAY || phase_q == PH_B0)

endmodule

[hw/rtl/wsfd_obuf.sv]
// Result register with skid stage between parser and output stream.
// Depends on wsfd_pkg and websocket_frame_deframer_assert.svh.
`timescale 1ns / 1ps
`include "websocket_frame_deframer_assert.svh"
module wsfd_obuf (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  wsfd_pkg::res_t in_res_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output wsfd_pkg::res_t out_res_o
);
  import wsfd_pkg::*;

  logic out_v_q, out_v_d;
  logic skid_v_q, skid_v_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;
  logic acc_in;
  logic slot_free;

  assign in_ready_o  = !skid_v_q;
  assign acc_in      = in_valid_i && !skid_v_q;
  assign slot_free   = !out_v_q || out_ready_i;
  assign out_valid_o = out_v_q;
  assign out_res_o   = out_q;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (slot_free) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        out_v_d  = 1'b1;
        skid_v_d = 1'b0;
      end else begin
        out_d   = in_res_i;
        out_v_d = acc_in;
      end
    end else if (acc_in) begin
      skid_d   = in_res_i;
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  `WSFD_ASSERT_IMPL(a_skid_behind_out, clk_i, rst_ni, skid_v_q, out_v_q)
  `WSFD_ASSERT_NEXT(a_skid_drains, clk_i, rst_ni, skid_v_q && out_ready_i, out_v_q && !skid_v_q)

endmodule

[hw/rtl/websocket_frame_deframer.sv]
// Channel   Dir  Signals                          Payload
// s_axis    in   tvalid/tready/tdata[7:0]         raw stream byte
// m_axis    out  tvalid/tready/tdata[87:0]/tuser  result per byte, tlast = frame end
// One item in, one item out; a new byte is taken every cycle while tready is high.
// Parser logic is combinational and feeds the result register directly.
// Stalls on m_axis are absorbed by a one-entry skid stage; tready drops only when it is full.
// Reset is asynchronous; no clearing pass, parsing starts at the first header byte.
// Top level of the WebSocket deframer; depends on wsfd_pkg, wsfd_parser, wsfd_obuf.
`timescale 1ns / 1ps
module websocket_frame_deframer #(
  parameter int LENGTH_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] out_byte, [8] fin_flag, [11:9] rsv_bits, [15:12] frame_opcode,
  // [16] masked_flag, [79:17] frame_length, [83:80] header_bytes, [87:84] zero
  output logic [87:0] m_axis_tdata_o,
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o    // frame_last
);
  import wsfd_pkg::*;

  logic accept;
  res_t res;
  res_t out_res;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  wsfd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (s_axis_tdata_i),
    .res_o       (res)
  );

  wsfd_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_res_i    (res),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata_o = {4'd0, out_res.header_bytes, out_res.frame_length,
                           out_res.masked_flag, out_res.frame_opcode, out_res.rsv_bits,
                           out_res.fin_flag, out_res.out_byte};
  assign m_axis_tuser_o = out_res.kind;
  assign m_axis_tlast_o = out_res.frame_last;

endmodule
